// ===== design/utspc_pkg.sv =====
// Package for the UDP/TCP service port classifier.
// Holds operation and result codes, the fixed well-known port tables and field widths.
// No dependencies; imported by every module of the classifier.
package utspc_pkg;

    localparam int PORT_W = 16;
    localparam int OP_W   = 2;
    localparam int KIND_W = 4;
    localparam int HOUT_W = 8;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;

    // Result kinds carried in m_tuser
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_TRANSIENT  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DHCP       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_TFTP       = 4'd3;
    localparam logic [KIND_W-1:0] KIND_NTP        = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RIP        = 4'd5;
    localparam logic [KIND_W-1:0] KIND_WELL_KNOWN = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ADDED      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_FULL       = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DELETED    = 4'd9;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [PORT_W-1:0] PORT_DHCP_SERVER = 16'd67;
    localparam logic [PORT_W-1:0] PORT_DHCP_CLIENT = 16'd68;
    localparam logic [PORT_W-1:0] PORT_TFTP        = 16'd69;
    localparam logic [PORT_W-1:0] PORT_NTP         = 16'd123;
    localparam logic [PORT_W-1:0] PORT_RIP         = 16'd520;

    localparam int UDP_COUNT = 20;
    localparam int TCP_COUNT = 43;

    localparam logic [PORT_W-1:0] UDP_PORTS [UDP_COUNT] = '{
        16'd7, 16'd9, 16'd13, 16'd19, 16'd37, 16'd42, 16'd53, 16'd67, 16'd68, 16'd69,
        16'd79, 16'd123, 16'd512, 16'd513, 16'd514, 16'd517, 16'd520, 16'd550,
        16'd560, 16'd561
    };

    localparam logic [PORT_W-1:0] TCP_PORTS [TCP_COUNT] = '{
        16'd1, 16'd7, 16'd9, 16'd11, 16'd13, 16'd15, 16'd19, 16'd20, 16'd21, 16'd23,
        16'd25, 16'd37, 16'd39, 16'd42, 16'd43, 16'd53, 16'd67, 16'd68, 16'd69,
        16'd77, 16'd79, 16'd87, 16'd95, 16'd101, 16'd102, 16'd103, 16'd104, 16'd105,
        16'd109, 16'd113, 16'd117, 16'd119, 16'd123, 16'd144, 16'd512, 16'd513,
        16'd514, 16'd515, 16'd530, 16'd540, 16'd600, 16'd1524, 16'd6000
    };

endpackage

// ===== design/utspc_wk_match.sv =====
// Well-known port lookup for one port against the TCP or UDP table.
// Depends on utspc_pkg for the port tables and protocol numbers.
module utspc_wk_match
    import utspc_pkg::*;
(
    input  logic [7:0]        protocol,
    input  logic [PORT_W-1:0] port,
    output logic              hit
);

    logic tcp_hit;
    logic udp_hit;

    // Compare against every table entry in parallel
    always_comb
    begin
        tcp_hit = 1'b0;
        udp_hit = 1'b0;
        for (int i = 0; i < TCP_COUNT; i++)
        begin
            if (TCP_PORTS[i] == port)
            begin
                tcp_hit = 1'b1;
            end
        end
        for (int i = 0; i < UDP_COUNT; i++)
        begin
            if (UDP_PORTS[i] == port)
            begin
                udp_hit = 1'b1;
            end
        end
    end

    assign hit = ((protocol == PROTO_TCP) && tcp_hit) || ((protocol == PROTO_UDP) && udp_hit);

endmodule

// ===== design/udp_tcp_service_port_classifier.sv =====
// Top level of the UDP/TCP service port classifier: stream ports, sequencer, transient table.
// Depends on utspc_pkg and instantiates utspc_wk_match for the source and destination ports.
//
// The block takes one operation per input transfer (s_tuser selects classify, add or delete)
// and returns exactly one result transfer for each. A classify first matches the source port,
// then the destination port, against the fixed well-known table of its protocol (TCP or UDP);
// a hit returns the service and peer ports and, with a nonzero payload, steers DHCP, TFTP, NTP
// and RIP traffic to their decoders. Without a hit the transient table is walked one entry per
// cycle through the single read port of its memory, a source match winning over a destination
// match. Add claims the first deleted slot or else the next never-used slot, rejecting port zero
// and a full table; delete marks every matching live entry as deleted. Entries are never
// emptied again, so a fill count marks the used prefix of the memory: no clearing pass is needed
// after reset and the block is ready on the first cycle. A well-known hit, a rejected add
// and an unused opcode go from the evaluate state straight to the done state, with no walk;
// a table operation first walks the memory over every slot ever claimed, which is at most
// TRANSIENT_DEPTH slots, before it reaches the done state.
// A source match on a classify or a reused deleted slot on an add ends the walk
// early. A new item is accepted once the previous result sits in the output register,
// even while that result still waits for m_tready.
module udp_tcp_service_port_classifier
    import utspc_pkg::*;
#(
    parameter int TRANSIENT_DEPTH = 64,
    parameter int HANDLER_WIDTH   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // protocol[7:0], sport[23:8], dport[39:24], payload_length[55:40],
    // transient_port[71:56], handler_in[79:72]
    input  logic [79:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // handler_out[7:0], reply_direction[8], service_port[24:9], peer_port[40:25], zero fill
    output logic [47:0] m_tdata,
    // result_kind[3:0]
    output logic [3:0]  m_tuser
);

    localparam int AW = $clog2(TRANSIENT_DEPTH);
    localparam int CW = $clog2(TRANSIENT_DEPTH + 1);
    localparam int HW = HANDLER_WIDTH;
    // Memory word: deleted flag, port, handler
    localparam int MW = 1 + PORT_W + HW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Control
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic          rdv_reg, rdv_next;
    logic          out_valid_reg;
    logic          out_load;

    // Captured item
    logic [OP_W-1:0]   op_reg;
    logic [7:0]        proto_reg;
    logic [PORT_W-1:0] src_reg;
    logic [PORT_W-1:0] dst_reg;
    logic              plen_nz_reg;
    logic [PORT_W-1:0] tport_reg;
    logic [HW-1:0]     hin_reg;
    logic [HW+7:0]     hin_wide;

    // Scan tracking
    logic [AW-1:0]     ridx_reg, ridx_next;
    logic              dfound_reg, dfound_next;
    logic [HOUT_W-1:0] dhdl_reg, dhdl_next;

    // Pending result
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [HOUT_W-1:0] hout_reg, hout_next;
    logic              reply_reg, reply_next;
    logic [PORT_W-1:0] svc_reg, svc_next;
    logic [PORT_W-1:0] peer_reg, peer_next;

    // Output register
    logic [47:0] m_tdata_reg;
    logic [3:0]  m_tuser_reg;

    // Transient table memory
    logic [MW-1:0] mem [TRANSIENT_DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;

    logic              rd_del;
    logic [PORT_W-1:0] rd_port;
    logic [HW-1:0]     rd_hdl;
    logic [HW+7:0]     rd_hdl_wide;
    logic [HOUT_W-1:0] rd_hdl8;
    logic              rd_used;

    logic          wk_src;
    logic          wk_dst;
    logic          issue;
    logic          take_in;
    logic [PORT_W-1:0] svc_sel;

    utspc_wk_match u_wk_src
    (
        .protocol (proto_reg),
        .port     (src_reg),
        .hit      (wk_src)
    );

    utspc_wk_match u_wk_dst
    (
        .protocol (proto_reg),
        .port     (dst_reg),
        .hit      (wk_dst)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign take_in  = s_tvalid && s_tready;
    assign hin_wide = {{HW{1'b0}}, s_tdata[79:72]};

    assign rd_del      = rd_data_reg[MW-1];
    assign rd_port     = rd_data_reg[HW +: PORT_W];
    assign rd_hdl      = rd_data_reg[HW-1:0];
    assign rd_hdl_wide = {8'd0, rd_hdl};
    assign rd_hdl8     = rd_hdl_wide[HOUT_W-1:0];
    assign rd_used     = !rd_del;

    assign issue   = (addr_reg != fill_reg);
    assign svc_sel = wk_src ? src_reg : dst_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        addr_next   = addr_reg;
        rdv_next    = 1'b0;
        ridx_next   = ridx_reg;
        dfound_next = dfound_reg;
        dhdl_next   = dhdl_reg;
        kind_next   = kind_reg;
        hout_next   = hout_reg;
        reply_next  = reply_reg;
        svc_next    = svc_reg;
        peer_next   = peer_reg;
        mem_we      = 1'b0;
        mem_wa      = ridx_reg;
        mem_wd      = {1'b0, tport_reg, hin_reg};
        rd_addr     = addr_reg[AW-1:0];
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                kind_next   = KIND_UNKNOWN;
                hout_next   = '0;
                reply_next  = 1'b0;
                svc_next    = '0;
                peer_next   = '0;
                addr_next   = '0;
                dfound_next = 1'b0;
                dhdl_next   = '0;
                unique case (op_reg)
                    OP_CLASSIFY:
                    begin
                        if (wk_src || wk_dst)
                        begin
                            // Source port first: a reply from the service
                            reply_next = wk_src;
                            svc_next   = svc_sel;
                            peer_next  = wk_src ? dst_reg : src_reg;
                            kind_next  = KIND_WELL_KNOWN;
                            if (plen_nz_reg)
                            begin
                                case (svc_sel)
                                    PORT_DHCP_SERVER, PORT_DHCP_CLIENT: kind_next = KIND_DHCP;
                                    PORT_TFTP: kind_next = KIND_TFTP;
                                    PORT_NTP:  kind_next = KIND_NTP;
                                    PORT_RIP:  kind_next = KIND_RIP;
                                    default:   kind_next = KIND_WELL_KNOWN;
                                endcase
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_ADD:
                    begin
                        if (tport_reg == '0)
                        begin
                            kind_next  = KIND_DELETED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_DELETE:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // Issue one read per cycle over the claimed prefix
                rdv_next  = issue;
                ridx_next = addr_reg[AW-1:0];
                if (issue)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                if (rdv_reg)
                begin
                    case (op_reg)
                        OP_CLASSIFY:
                        begin
                            if (rd_used && (rd_port == src_reg))
                            begin
                                kind_next  = KIND_TRANSIENT;
                                hout_next  = rd_hdl8;
                                rdv_next   = 1'b0;
                                state_next = S_DONE;
                            end
                            else if (rd_used && (rd_port == dst_reg) && !dfound_reg)
                            begin
                                // Hold the first destination match until the walk ends
                                dfound_next = 1'b1;
                                dhdl_next   = rd_hdl8;
                            end
                        end
                        OP_ADD:
                        begin
                            if (rd_del)
                            begin
                                mem_we     = 1'b1;
                                kind_next  = KIND_ADDED;
                                rdv_next   = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (rd_used && (rd_port == tport_reg))
                            begin
                                mem_we = 1'b1;
                                mem_wd = {1'b1, rd_port, rd_hdl};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (!issue)
                begin
                    // Walk finished without an early stop
                    state_next = S_DONE;
                    case (op_reg)
                        OP_CLASSIFY:
                        begin
                            if (dfound_reg)
                            begin
                                kind_next = KIND_TRANSIENT;
                                hout_next = dhdl_reg;
                            end
                        end
                        OP_ADD:
                        begin
                            if (fill_reg < CW'(TRANSIENT_DEPTH))
                            begin
                                mem_we    = 1'b1;
                                mem_wa    = fill_reg[AW-1:0];
                                fill_next = fill_reg + CW'(1);
                                kind_next = KIND_ADDED;
                            end
                            else
                            begin
                                kind_next = KIND_FULL;
                            end
                        end
                        OP_DELETE:
                        begin
                            kind_next = KIND_DELETED;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            addr_reg      <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            addr_reg  <= addr_next;
            rdv_reg   <= rdv_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            op_reg      <= s_tuser;
            proto_reg   <= s_tdata[7:0];
            src_reg     <= s_tdata[23:8];
            dst_reg     <= s_tdata[39:24];
            plen_nz_reg <= (s_tdata[55:40] != '0);
            tport_reg   <= s_tdata[71:56];
            hin_reg     <= hin_wide[HW-1:0];
        end
        ridx_reg   <= ridx_next;
        dfound_reg <= dfound_next;
        dhdl_reg   <= dhdl_next;
        kind_reg   <= kind_next;
        hout_reg   <= hout_next;
        reply_reg  <= reply_next;
        svc_reg    <= svc_next;
        peer_reg   <= peer_next;
        if (out_load)
        begin
            m_tdata_reg <= {7'd0, peer_reg, svc_reg, reply_reg, hout_reg};
            m_tuser_reg <= kind_reg;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN))
        else $error("table written outside the walk");

    a_fill_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("fill count moved by other than one");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(TRANSIENT_DEPTH))
        else $error("fill count beyond table depth");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rdv_reg |-> (state_reg == S_SCAN))
        else $error("read in flight outside the walk");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded without a finished item");

endmodule

// ===== dv/service_port_checker.sv =====
// Checker for the UDP/TCP service port classifier: watches both stream channels,
// keeps its own copy of the transient port table and compares every result transfer.
// Depends on utspc_pkg for operation codes, result kinds and the well-known port tables.
`timescale 1ns / 1ps

module service_port_checker
    import utspc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int unsigned fail_count,
    output int unsigned verdicts_owed
);

    localparam int TABLE_DEPTH = 64;

    typedef enum logic [1:0] {
        SLOT_EMPTY,
        SLOT_LIVE,
        SLOT_DEAD
    } slot_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        handler;
        logic              reply;
        logic [15:0]       service;
        logic [15:0]       peer;
    } verdict_t;

    slot_state_t slot_state   [TABLE_DEPTH];
    logic [15:0] slot_port    [TABLE_DEPTH];
    logic [7:0]  slot_handler [TABLE_DEPTH];
    verdict_t    verdicts_due [$];
    int unsigned errors;

    function automatic bit is_well_known(logic [7:0] proto, logic [15:0] port);
        bit hit;
        hit = 1'b0;
        if (proto == PROTO_TCP)
        begin
            for (int k = 0; k < TCP_COUNT; k++)
                if (TCP_PORTS[k] == port)
                    hit = 1'b1;
        end
        else if (proto == PROTO_UDP)
        begin
            for (int k = 0; k < UDP_COUNT; k++)
                if (UDP_PORTS[k] == port)
                    hit = 1'b1;
        end
        return hit;
    endfunction

    // Walk from slot 0, skip dead slots, stop at the first never-used one.
    function automatic int find_live_slot(logic [15:0] port);
        int found;
        found = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_state[i] == SLOT_EMPTY)
                break;
            if (slot_state[i] == SLOT_LIVE && slot_port[i] == port)
            begin
                found = i;
                break;
            end
        end
        return found;
    endfunction

    // Compute the verdict for one operation and update the table copy.
    function automatic verdict_t predict_verdict(logic [1:0] op, logic [79:0] d);
        verdict_t    v;
        logic [7:0]  proto;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] plen;
        logic [15:0] tport;
        logic [7:0]  hin;
        bit          src_hit;
        bit          dst_hit;
        int          idx;
        v     = '0;
        proto = d[7:0];
        src   = d[23:8];
        dst   = d[39:24];
        plen  = d[55:40];
        tport = d[71:56];
        hin   = d[79:72];
        case (op)
            OP_CLASSIFY:
            begin
                src_hit = is_well_known(proto, src);
                dst_hit = is_well_known(proto, dst);
                if (src_hit || dst_hit)
                begin
                    v.reply   = src_hit;
                    v.service = src_hit ? src : dst;
                    v.peer    = src_hit ? dst : src;
                    v.kind    = KIND_WELL_KNOWN;
                    if (plen != 16'd0)
                    begin
                        if (v.service == PORT_DHCP_SERVER || v.service == PORT_DHCP_CLIENT)
                            v.kind = KIND_DHCP;
                        else if (v.service == PORT_TFTP)
                            v.kind = KIND_TFTP;
                        else if (v.service == PORT_NTP)
                            v.kind = KIND_NTP;
                        else if (v.service == PORT_RIP)
                            v.kind = KIND_RIP;
                    end
                end
                else
                begin
                    idx = find_live_slot(src);
                    if (idx < 0)
                        idx = find_live_slot(dst);
                    if (idx >= 0)
                    begin
                        v.kind    = KIND_TRANSIENT;
                        v.handler = slot_handler[idx];
                    end
                end
            end
            OP_ADD:
            begin
                // port zero is refused with the same kind as a delete
                if (tport == 16'd0)
                    v.kind = KIND_DELETED;
                else
                begin
                    v.kind = KIND_FULL;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (slot_state[i] != SLOT_LIVE)
                        begin
                            slot_state[i]   = SLOT_LIVE;
                            slot_port[i]    = tport;
                            slot_handler[i] = hin;
                            v.kind          = KIND_ADDED;
                            break;
                        end
                    end
                end
            end
            OP_DELETE:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_state[i] == SLOT_EMPTY)
                        break;
                    if (slot_state[i] == SLOT_LIVE && slot_port[i] == tport)
                        slot_state[i] = SLOT_DEAD;
                end
                v.kind = KIND_DELETED;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_state[i] = SLOT_EMPTY;
            verdicts_due.delete();
            errors = 0;
            fail_count <= 0;
            verdicts_owed <= 0;
        end
        else
        begin
            // Check the result first: it can never belong to an item taken at this edge.
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("unexpected result, kind", 16'(m_tuser), 16'd0);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("result_kind", 16'(m_tuser), 16'(want.kind));
                    if (m_tdata[7:0] !== want.handler)
                        report_mismatch("handler_out", 16'(m_tdata[7:0]), 16'(want.handler));
                    if (m_tdata[8] !== want.reply)
                        report_mismatch("reply_direction", 16'(m_tdata[8]), 16'(want.reply));
                    if (m_tdata[24:9] !== want.service)
                        report_mismatch("service_port", m_tdata[24:9], want.service);
                    if (m_tdata[40:25] !== want.peer)
                        report_mismatch("peer_port", m_tdata[40:25], want.peer);
                end
            end
            if (s_tvalid && s_tready)
                verdicts_due.push_back(predict_verdict(s_tuser, s_tdata));
            fail_count <= errors;
            verdicts_owed <= verdicts_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the testbench for the UDP/TCP service port classifier: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on utspc_pkg, the classifier RTL and
// service_port_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench
    import utspc_pkg::*;
();

    // Opcode 3 has no name in the package; the block must answer it with all zeros.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS    = 1550;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 100;   // margin beyond the longest table walk
    localparam int WATCHDOG_LIMIT = 4000;  // idle cycles; hold-off plus a full walk, many times

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      proto;
        logic [15:0]     src;
        logic [15:0]     dst;
        logic [15:0]     plen;
        logic [15:0]     tport;
        logic [7:0]      hin;
    } port_op_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // protocol[7:0], sport[23:8], dport[39:24], payload_length[55:40],
    // transient_port[71:56], handler_in[79:72]
    logic [79:0] s_tdata;
    // opcode[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // handler_out[7:0], reply_direction[8], service_port[24:9], peer_port[40:25], zero fill
    logic [47:0] m_tdata;
    // result_kind[3:0]
    logic [3:0]  m_tuser;

    int unsigned fail_count;
    int unsigned verdicts_owed;

    bit          hold_request;
    int          items_sent;
    int          burst_left;
    int          idle_cycles;
    logic [15:0] added_ports [$];  // ports handed to add, reused to hit the table

    udp_tcp_service_port_classifier dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    service_port_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog: count cycles in which neither channel completes a transfer.
    initial
    begin
        idle_cycles = 0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: stall on a pattern that changes every so often; on request hold off
    // for a long stretch so the output register fills and the block stops taking input.
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        m_tready = 1'b0;
        mode     = 0;
        span     = 0;
        tick     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 200);
            end
            span--;
            tick++;
            case (mode)
                0: m_tready <= 1'b1;                               // no stalls at all
                1: m_tready <= ($urandom_range(0, 1) == 1);        // coin flip
                2: m_tready <= ($urandom_range(0, 3) == 0);        // mostly stalled
                default: m_tready <= ((tick % 5) != 0);            // periodic gap
            endcase
        end
    end

    // Offer one operation, hold it until the block takes it, then advance the burst:
    // at the end of a burst drop tvalid for a random gap, unless the gap is zero.
    task automatic offer(input port_op_t it);
        int gap;
        s_tdata  <= {it.hin, it.tport, it.plen, it.dst, it.src, it.proto};
        s_tuser  <= it.op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic offer_fields(input logic [OP_W-1:0] op, input logic [7:0] proto,
                                input logic [15:0] src, input logic [15:0] dst,
                                input logic [15:0] plen, input logic [15:0] tport,
                                input logic [7:0] hin);
        port_op_t it;
        it = '{op, proto, src, dst, plen, tport, hin};
        offer(it);
    endtask

    // Stop offering and wait until every outstanding result has come back.
    // The first edge lets the checker count an item taken at the last edge.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
    endtask

    // Mix of well-known ports, ports already added, low ports and anything at all.
    function automatic logic [15:0] pick_port();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 1) ? TCP_PORTS[$urandom_range(0, TCP_COUNT - 1)]
                                        : UDP_PORTS[$urandom_range(0, UDP_COUNT - 1)];
        if (r < 60 && added_ports.size() > 0)
            return added_ports[$urandom_range(0, added_ports.size() - 1)];
        if (r < 80)
            return 16'($urandom_range(1, 300));
        return 16'($urandom());
    endfunction

    function automatic port_op_t random_op(input logic [OP_W-1:0] op);
        port_op_t    it;
        int unsigned r;
        it.op    = op;
        r        = $urandom_range(0, 99);
        it.proto = (r < 40) ? PROTO_TCP : (r < 80) ? PROTO_UDP : 8'($urandom());
        it.src   = pick_port();
        it.dst   = pick_port();
        it.plen  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom());
        it.tport = 16'($urandom());
        it.hin   = 8'($urandom());
        if (op == OP_ADD)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                it.tport = 16'd0;
            else if (r < 10)
                it.tport = 16'hFFFF;
            else if (r < 75)
                it.tport = 16'($urandom_range(1, 300));
            if (it.tport != 16'd0)
            begin
                added_ports.push_back(it.tport);
                if (added_ports.size() > 200)
                    void'(added_ports.pop_front());
            end
        end
        else if (op == OP_DELETE)
        begin
            if (added_ports.size() > 0 && $urandom_range(0, 9) < 7)
                it.tport = added_ports[$urandom_range(0, added_ports.size() - 1)];
            else
                it.tport = pick_port();
        end
        return it;
    endfunction

    initial
    begin : stimulus
        int          episode;
        int          count;
        int unsigned r;
        logic [OP_W-1:0] op;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_CLASSIFY;
        hold_request = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, rejected add, field extremes, every result kind but full,
        // source-first precedence, tombstones and their reuse, the unused opcode.
        offer_fields(OP_CLASSIFY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        offer_fields(OP_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF);
        offer_fields(OP_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 8'hFF);
        offer_fields(OP_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 8'h00);
        offer_fields(OP_CLASSIFY, PROTO_TCP, 16'd21, 16'hFFFF, 16'd0, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd40000, 16'd67, 16'd1, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd68, 16'd9, 16'hFFFF, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd5000, 16'd69, 16'd5, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd123, 16'd123, 16'd1, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd30000, 16'd520, 16'd1, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd30000, 16'd520, 16'd0, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_TCP, 16'd1524, 16'd6000, 16'd200, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_TCP, 16'd67, 16'd80, 16'd9, 16'd0, 8'd0);
        // 520 is not a TCP service, so the transient table answers through dst
        offer_fields(OP_CLASSIFY, PROTO_TCP, 16'd520, 16'd1000, 16'd1, 16'd0, 8'd0);
        // other protocol: only the transient table
        offer_fields(OP_CLASSIFY, 8'hFF, 16'd67, 16'hFFFF, 16'd1, 16'd0, 8'd0);
        offer_fields(OP_CLASSIFY, 8'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd0, 8'd0);
        offer_fields(OP_DELETE, 8'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 8'd0);
        offer_fields(OP_CLASSIFY, 8'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd0, 8'd0);
        offer_fields(OP_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 16'd2000, 8'hAA);
        offer_fields(OP_DELETE, 8'd0, 16'd0, 16'd0, 16'd0, 16'd12345, 8'd0);
        offer_fields(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        offer_fields(OP_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 8'h55);
        offer_fields(OP_CLASSIFY, PROTO_UDP, 16'd1000, 16'd2000, 16'd0, 16'd0, 8'd0);
        offer_fields(OP_DELETE, 8'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 8'd0);
        offer_fields(OP_CLASSIFY, PROTO_TCP, 16'd1000, 16'd2000, 16'd0, 16'd0, 8'd0);

        // Random part in episodes: fill the table past full, purge it, or mix all
        // operations. The first episode always fills so full rejections are reached.
        episode = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (episode == 1 || $urandom_range(0, 15) == 0)
                hold_request = 1'b1;
            if (episode == 3 || $urandom_range(0, 7) == 0)
                drain_results();
            r = (episode == 0) ? 0 : $urandom_range(0, 5);
            case (r)
                0:
                begin
                    count = (episode == 0) ? 80 : $urandom_range(40, 75);
                    repeat (count) offer(random_op(OP_ADD));
                end
                1:
                begin
                    count = $urandom_range(5, 30);
                    repeat (count) offer(random_op(OP_DELETE));
                end
                default:
                begin
                    count = $urandom_range(20, 60);
                    repeat (count)
                    begin
                        r  = $urandom_range(0, 99);
                        op = (r < 55) ? OP_CLASSIFY : (r < 78) ? OP_ADD
                           : (r < 95) ? OP_DELETE : OP_UNUSED;
                        offer(random_op(op));
                    end
                end
            endcase
            episode++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
